// File: rtl/core/wtq_pkg.sv
// Shared types and constants for the wrapping timer queue.
`default_nettype none

package wtq_pkg;

    // default number of timer slots
    localparam int TIMER_SLOTS_DEF = 16;

    // field widths fixed by the interface
    localparam int ID_W    = 4;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;
    localparam int MIN_W   = 16;

    // operation codes
    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_CANCEL   = 1'b1;

    // status codes
    localparam logic ST_CHANGED   = 1'b0;
    localparam logic ST_UNCHANGED = 1'b1;

    // configuration register indexes
    localparam logic CFG_MIN_UNIT     = 1'b0;
    localparam logic CFG_DEFAULT_UNIT = 1'b1;

    // configuration reset values
    localparam logic [MIN_W-1:0]  MIN_UNIT_RST     = 16'd10;
    localparam logic [TIME_W-1:0] DEFAULT_UNIT_RST = 32'd1000;

    // reciprocal of five for a 32-bit dividend: floor(x / 5) = (x * RECIP5) >> 34
    localparam logic [TIME_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int                RECIP5_SHIFT = 34;

    // request from the queue controller to the scheduling unit tracker
    typedef struct packed {
        logic              lower;
        logic [TIME_W-1:0] interval;
    } t_unit_req;

endpackage

`default_nettype wire

// File: rtl/core/wtq_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module wtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read port with held output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/wtq_unit.sv
// Scheduling unit tracker: configuration registers and interval-based lowering.
`default_nettype none

module wtq_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_index,
    input  wire logic [wtq_pkg::TIME_W-1:0]   i_cfg_data,
    input  wire wtq_pkg::t_unit_req           i_req,
    output logic      [wtq_pkg::TIME_W-1:0]   o_unit
);

    localparam int PROD_W = 2 * wtq_pkg::TIME_W;
    localparam int QUOT_W = PROD_W - wtq_pkg::RECIP5_SHIFT;

    logic [wtq_pkg::MIN_W-1:0]  r_min_unit;
    logic [wtq_pkg::TIME_W-1:0] r_def_unit;
    logic                       r_lowered;
    logic [wtq_pkg::TIME_W-1:0] r_low_unit;
    logic [wtq_pkg::TIME_W-1:0] r_slice;

    logic [PROD_W-1:0]          w_prod;
    logic [wtq_pkg::TIME_W-1:0] w_cur;
    logic [wtq_pkg::TIME_W-1:0] w_min_ext;
    logic [wtq_pkg::TIME_W-1:0] n_low_unit;

    // divide the interval by five through the reciprocal
    assign w_prod = {{wtq_pkg::TIME_W{1'b0}}, i_req.interval}
                  * {{wtq_pkg::TIME_W{1'b0}}, wtq_pkg::RECIP5};

    assign w_cur      = r_lowered ? r_low_unit : r_def_unit;
    assign w_min_ext  = {{(wtq_pkg::TIME_W - wtq_pkg::MIN_W){1'b0}}, r_min_unit};
    assign n_low_unit = (r_slice > w_min_ext) ? r_slice : w_min_ext;

    // hold the quotient for the lowering step
    always_ff @(posedge i_clk) begin
        r_slice <= {{(wtq_pkg::TIME_W - QUOT_W){1'b0}}, w_prod[PROD_W-1:wtq_pkg::RECIP5_SHIFT]};
    end

    // configuration writes and lowering of the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_unit <= wtq_pkg::MIN_UNIT_RST;
            r_def_unit <= wtq_pkg::DEFAULT_UNIT_RST;
            r_lowered  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wtq_pkg::CFG_MIN_UNIT: begin
                        r_min_unit <= i_cfg_data[wtq_pkg::MIN_W-1:0];
                    end
                    wtq_pkg::CFG_DEFAULT_UNIT: begin
                        r_def_unit <= i_cfg_data;
                    end
                    default: begin
                        r_def_unit <= r_def_unit;
                    end
                endcase
            end
            if (i_req.lower && (r_slice < w_cur)) begin
                r_lowered  <= 1'b1;
                r_low_unit <= n_low_unit;
            end
        end
    end

    assign o_unit = w_cur;

endmodule

`default_nettype wire

// File: rtl/core/wtq_ctrl.sv
// Queue controller: walks, shifts and reads back the ordered slot queue.
`default_nettype none

module wtq_ctrl #(
    parameter int TIMER_SLOTS = wtq_pkg::TIMER_SLOTS_DEF,
    localparam int SW = $clog2(TIMER_SLOTS),
    localparam int CW = $clog2(TIMER_SLOTS + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_operation,
    input  wire logic [wtq_pkg::ID_W-1:0]       i_timer_id,
    input  wire logic [wtq_pkg::TIME_W-1:0]     i_interval_ms,
    input  wire logic [wtq_pkg::TIME_W-1:0]     i_now_ms,
    // slot store: {timestamp, fire time}
    output logic                                o_slot_we,
    output logic      [SW-1:0]                  o_slot_waddr,
    output logic      [2*wtq_pkg::TIME_W-1:0]   o_slot_wdata,
    output logic                                o_slot_re,
    output logic      [SW-1:0]                  o_slot_raddr,
    input  wire logic [2*wtq_pkg::TIME_W-1:0]   i_slot_rdata,
    // queue order store
    output logic                                o_ord_we,
    output logic      [SW-1:0]                  o_ord_waddr,
    output logic      [SW-1:0]                  o_ord_wdata,
    output logic                                o_ord_re,
    output logic      [SW-1:0]                  o_ord_raddr,
    input  wire logic [SW-1:0]                  i_ord_rdata,
    output wtq_pkg::t_unit_req                  o_unit_req,
    output logic                                o_result_valid,
    output logic                                o_status,
    output logic      [wtq_pkg::ID_W-1:0]       o_head_timer_id,
    output logic      [wtq_pkg::TIME_W-1:0]     o_head_fire_time,
    output logic      [wtq_pkg::COUNT_W-1:0]    o_queue_count
);

    localparam int            RW     = 9;
    localparam logic [RW-1:0] SLOTS_R = RW'(TIMER_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK0,
        S_WALK,
        S_CWALK,
        S_SHIFT,
        S_HEAD0,
        S_HEAD1,
        S_HEAD2
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_op, n_op;
    logic [wtq_pkg::ID_W-1:0]   r_id, n_id;
    logic [wtq_pkg::TIME_W-1:0] r_interval, n_interval;
    logic [wtq_pkg::TIME_W-1:0] r_now, n_now;
    logic [wtq_pkg::TIME_W-1:0] r_fire, n_fire;
    logic [CW-1:0]              r_len, n_len;
    logic [TIMER_SLOTS-1:0]     r_active, n_active;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_src, n_src;
    logic [CW-1:0]              r_last, n_last;
    logic [CW-1:0]              r_rem, n_rem;
    logic                       r_pend, n_pend;
    logic                       r_del, n_del;
    logic                       r_status, n_status;
    logic                       r_lower, n_lower;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_status, n_out_status;
    logic [wtq_pkg::ID_W-1:0]   r_out_head_id, n_out_head_id;
    logic [wtq_pkg::TIME_W-1:0] r_out_head_fire, n_out_head_fire;
    logic [wtq_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    // wraparound-aware window test of a new fire time against an entry
    function automatic logic f_goes_before(input logic [wtq_pkg::TIME_W-1:0] fire,
                                           input logic [2*wtq_pkg::TIME_W-1:0] ent);
        logic [wtq_pkg::TIME_W-1:0] s;
        logic [wtq_pkg::TIME_W-1:0] t;
        s = ent[2*wtq_pkg::TIME_W-1:wtq_pkg::TIME_W];
        t = ent[wtq_pkg::TIME_W-1:0];
        if (s <= t) begin
            f_goes_before = (fire >= s) && (fire < t);
        end else begin
            f_goes_before = (fire >= s) || (fire < t);
        end
    endfunction

    // next-state and memory port logic
    always_comb begin
        logic [SW-1:0] v_slot;
        logic          v_in_range;
        logic [CW-1:0] v_pos;
        logic          v_enter_ins;

        v_slot      = SW'(r_id);
        v_in_range  = ({{(RW - wtq_pkg::ID_W){1'b0}}, r_id} < SLOTS_R);
        v_pos       = r_len;
        v_enter_ins = 1'b0;

        n_state         = r_state;
        n_op            = r_op;
        n_id            = r_id;
        n_interval      = r_interval;
        n_now           = r_now;
        n_fire          = r_fire;
        n_len           = r_len;
        n_active        = r_active;
        n_idx           = r_idx;
        n_pos           = r_pos;
        n_src           = r_src;
        n_last          = r_last;
        n_rem           = r_rem;
        n_pend          = r_pend;
        n_del           = r_del;
        n_status        = r_status;
        n_lower         = 1'b0;
        n_out_valid     = 1'b0;
        n_out_status    = r_out_status;
        n_out_head_id   = r_out_head_id;
        n_out_head_fire = r_out_head_fire;
        n_out_count     = r_out_count;

        o_slot_we    = 1'b0;
        o_slot_waddr = v_slot;
        o_slot_wdata = {r_now, r_fire};
        o_slot_re    = 1'b0;
        o_slot_raddr = i_ord_rdata;
        o_ord_we     = 1'b0;
        o_ord_waddr  = SW'(r_pos);
        o_ord_wdata  = v_slot;
        o_ord_re     = 1'b0;
        o_ord_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                // take the transfer and hold its fields
                if (i_start) begin
                    n_op       = i_operation;
                    n_id       = i_timer_id;
                    n_interval = i_interval_ms;
                    n_now      = i_now_ms;
                    n_fire     = i_now_ms + i_interval_ms;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (v_in_range && (r_op == wtq_pkg::OP_REGISTER) && !r_active[v_slot]) begin
                    // record the slot and look for its place
                    n_active[v_slot] = 1'b1;
                    o_slot_we        = 1'b1;
                    n_status         = wtq_pkg::ST_CHANGED;
                    if ((r_interval == '0) || (r_len == '0)) begin
                        v_pos       = '0;
                        v_enter_ins = 1'b1;
                    end else begin
                        o_ord_re = 1'b1;
                        n_state  = S_WALK0;
                    end
                end else if (v_in_range && (r_op == wtq_pkg::OP_CANCEL) && r_active[v_slot]) begin
                    // drop the slot, then find it in the queue
                    n_active[v_slot] = 1'b0;
                    n_status         = wtq_pkg::ST_CHANGED;
                    o_ord_re         = 1'b1;
                    n_idx            = '0;
                    n_state          = S_CWALK;
                end else begin
                    n_status = wtq_pkg::ST_UNCHANGED;
                    n_state  = S_HEAD0;
                end
            end
            S_WALK0: begin
                // prime the walk: slot of entry zero, order of entry one
                o_slot_re   = 1'b1;
                o_ord_re    = 1'b1;
                o_ord_raddr = SW'(1);
                n_idx       = '0;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (f_goes_before(r_fire, i_slot_rdata)) begin
                    v_pos       = r_idx;
                    v_enter_ins = 1'b1;
                end else if ((r_idx + CW'(1)) == r_len) begin
                    v_pos       = r_len;
                    v_enter_ins = 1'b1;
                end else begin
                    // advance one entry per cycle
                    o_slot_re   = 1'b1;
                    o_ord_re    = 1'b1;
                    o_ord_raddr = SW'(r_idx + CW'(2));
                    n_idx       = r_idx + CW'(1);
                end
            end
            S_CWALK: begin
                if (i_ord_rdata == v_slot) begin
                    n_pos   = r_idx;
                    n_del   = 1'b1;
                    n_src   = r_idx + CW'(1);
                    n_rem   = r_len - r_idx - CW'(1);
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    o_ord_re    = 1'b1;
                    o_ord_raddr = SW'(r_idx + CW'(1));
                    n_idx       = r_idx + CW'(1);
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle
                if (r_pend) begin
                    o_ord_we    = 1'b1;
                    o_ord_waddr = r_del ? SW'(r_last - CW'(1)) : SW'(r_last + CW'(1));
                    o_ord_wdata = i_ord_rdata;
                end
                if (r_rem != '0) begin
                    o_ord_re    = 1'b1;
                    o_ord_raddr = SW'(r_src);
                    n_last      = r_src;
                    n_src       = r_del ? (r_src + CW'(1)) : (r_src - CW'(1));
                    n_rem       = r_rem - CW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // place the new slot, or finish the removal
                        if (!r_del) begin
                            o_ord_we = 1'b1;
                            n_lower  = 1'b1;
                            n_len    = r_len + CW'(1);
                        end else begin
                            n_len = r_len - CW'(1);
                        end
                        n_state = S_HEAD0;
                    end
                end
            end
            S_HEAD0: begin
                if (r_len == '0) begin
                    n_out_valid     = 1'b1;
                    n_out_status    = r_status;
                    n_out_head_id   = '0;
                    n_out_head_fire = '0;
                    n_out_count     = wtq_pkg::COUNT_W'(r_len);
                    n_state         = S_IDLE;
                end else begin
                    o_ord_re = 1'b1;
                    n_state  = S_HEAD1;
                end
            end
            S_HEAD1: begin
                o_slot_re     = 1'b1;
                n_out_head_id = wtq_pkg::ID_W'(i_ord_rdata);
                n_state       = S_HEAD2;
            end
            S_HEAD2: begin
                n_out_valid     = 1'b1;
                n_out_status    = r_status;
                n_out_head_fire = i_slot_rdata[wtq_pkg::TIME_W-1:0];
                n_out_count     = wtq_pkg::COUNT_W'(r_len);
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // set up the upward shift for an insertion at v_pos
        if (v_enter_ins) begin
            n_pos   = v_pos;
            n_del   = 1'b0;
            n_rem   = r_len - v_pos;
            n_src   = r_len - CW'(1);
            n_pend  = 1'b0;
            n_state = S_SHIFT;
        end
    end

    // state, counters and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_active    <= '0;
            r_pend      <= 1'b0;
            r_lower     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_len           <= n_len;
            r_active        <= n_active;
            r_pend          <= n_pend;
            r_lower         <= n_lower;
            r_out_valid     <= n_out_valid;
            r_op            <= n_op;
            r_id            <= n_id;
            r_interval      <= n_interval;
            r_now           <= n_now;
            r_fire          <= n_fire;
            r_idx           <= n_idx;
            r_pos           <= n_pos;
            r_src           <= n_src;
            r_last          <= n_last;
            r_rem           <= n_rem;
            r_del           <= n_del;
            r_status        <= n_status;
            r_out_status    <= n_out_status;
            r_out_head_id   <= n_out_head_id;
            r_out_head_fire <= n_out_head_fire;
            r_out_count     <= n_out_count;
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_unit_req.lower    = r_lower;
    assign o_unit_req.interval = r_interval;
    assign o_result_valid      = r_out_valid;
    assign o_status            = r_out_status;
    assign o_head_timer_id     = r_out_head_id;
    assign o_head_fire_time    = r_out_head_fire;
    assign o_queue_count       = r_out_count;

endmodule

`default_nettype wire

// File: rtl/core/wrapping_timer_queue_insert.sv
// Top level of the wrapping timer queue: controller, slot and order memories, unit tracker.
`default_nettype none

// Usage
//   Command channel: drive the fields with start high; the command is taken at
//   the clock edge where start is high and busy is low. Busy stays high until
//   the result is being shown.
//   Result channel: o_result_valid is high for exactly one cycle with status,
//   head slot, head fire time, queue count and scheduling unit. The receiver
//   cannot stall it; it must take the result in that cycle. A new command may
//   be taken in the same cycle as the strobe.
//   Configuration: write channel with i_cfg_valid and o_cfg_ready (always
//   ready); index 0 is the minimum unit, index 1 the default unit. Write only
//   while no command is in flight.
// Search and shift
//   The search of a register or cancel and the shift that follows are paced by
//   the single read port of the order memory, which serves one entry per cycle
//   during the search and during the shift.
// Reset
//   Synchronous active-low reset empties the queue, clears all active flags,
//   restores both unit registers and returns the unit to its default. No
//   memory clearing pass is needed.

module wrapping_timer_queue_insert #(
    parameter int TIMER_SLOTS = wtq_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_operation,
    input  wire logic [wtq_pkg::ID_W-1:0]     i_timer_id,
    input  wire logic [wtq_pkg::TIME_W-1:0]   i_interval_ms,
    input  wire logic [wtq_pkg::TIME_W-1:0]   i_now_ms,
    output logic                              o_result_valid,
    output logic                              o_status,
    output logic      [wtq_pkg::ID_W-1:0]     o_head_timer_id,
    output logic      [wtq_pkg::TIME_W-1:0]   o_head_fire_time,
    output logic      [wtq_pkg::COUNT_W-1:0]  o_queue_count,
    output logic      [wtq_pkg::TIME_W-1:0]   o_scheduling_unit,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [wtq_pkg::TIME_W-1:0]   i_cfg_data
);

    localparam int SW     = $clog2(TIMER_SLOTS);
    localparam int SLOT_W = 2 * wtq_pkg::TIME_W;

    logic              w_slot_we;
    logic [SW-1:0]     w_slot_waddr;
    logic [SLOT_W-1:0] w_slot_wdata;
    logic              w_slot_re;
    logic [SW-1:0]     w_slot_raddr;
    logic [SLOT_W-1:0] w_slot_rdata;
    logic              w_ord_we;
    logic [SW-1:0]     w_ord_waddr;
    logic [SW-1:0]     w_ord_wdata;
    logic              w_ord_re;
    logic [SW-1:0]     w_ord_raddr;
    logic [SW-1:0]     w_ord_rdata;
    wtq_pkg::t_unit_req w_unit_req;

    assign o_cfg_ready = 1'b1;

    // slot timestamps and fire times
    wtq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // queue order of slot numbers
    wtq_ram #(
        .WIDTH (SW),
        .DEPTH (TIMER_SLOTS)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (w_ord_waddr),
        .i_wdata (w_ord_wdata),
        .i_re    (w_ord_re),
        .i_raddr (w_ord_raddr),
        .o_rdata (w_ord_rdata)
    );

    wtq_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_operation      (i_operation),
        .i_timer_id       (i_timer_id),
        .i_interval_ms    (i_interval_ms),
        .i_now_ms         (i_now_ms),
        .o_slot_we        (w_slot_we),
        .o_slot_waddr     (w_slot_waddr),
        .o_slot_wdata     (w_slot_wdata),
        .o_slot_re        (w_slot_re),
        .o_slot_raddr     (w_slot_raddr),
        .i_slot_rdata     (w_slot_rdata),
        .o_ord_we         (w_ord_we),
        .o_ord_waddr      (w_ord_waddr),
        .o_ord_wdata      (w_ord_wdata),
        .o_ord_re         (w_ord_re),
        .o_ord_raddr      (w_ord_raddr),
        .i_ord_rdata      (w_ord_rdata),
        .o_unit_req       (w_unit_req),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_head_timer_id  (o_head_timer_id),
        .o_head_fire_time (o_head_fire_time),
        .o_queue_count    (o_queue_count)
    );

    wtq_unit u_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (w_unit_req),
        .o_unit      (o_scheduling_unit)
    );

    // a taken command always occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not make the block busy");

    // each command gives a single-cycle strobe
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // a strobe only follows a command in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a command in flight");

    // an empty queue reports a zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_queue_count == '0))
            |-> ((o_head_timer_id == '0) && (o_head_fire_time == '0)))
        else $error("empty queue reported a head entry");

endmodule

`default_nettype wire

// File: tb/wrapping_timer_queue_insert_tb.sv
// Self-checking testbench for the wrapping timer queue: directed table, then random traffic.
module wrapping_timer_queue_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtq_pkg::*;

    localparam int SLOTS          = TIMER_SLOTS_DEF;
    localparam int SETTLE_CYCLES  = SLOTS + 12;
    localparam int RANDOM_CHANGES = 800;
    localparam int PHASES         = 8;
    localparam int DIR_ROWS       = 21;
    localparam logic [TIME_W-1:0] UNIT_DIV = 32'd5;

    // what the block reports after each command
    typedef struct packed {
        logic               status;
        logic [ID_W-1:0]    head_id;
        logic [TIME_W-1:0]  head_fire;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  unit;
    } queue_view_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

    // one directed step; on register writes the data column carries the write data
    typedef struct packed {
        row_kind_e         kind;
        logic              op;
        logic              sel;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] data;
        logic [TIME_W-1:0] now;
        logic              typed;
        queue_view_t       view;
    } plan_row_t;

    plan_row_t dir_plan [DIR_ROWS] = '{
        // cancel on the empty queue straight after reset
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd0, 32'd0, 32'd0,
          1'b1, '{ST_UNCHANGED, 4'd0, 32'd0, 5'd0, 32'd1000}},
        // largest interval at the last tick: fire time wraps, unit stays
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, '{ST_CHANGED, 4'd15, 32'hFFFF_FFFE, 5'd1, 32'd1000}},
        // register of a slot already active
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd15, 32'd5, 32'd7,
          1'b1, '{ST_UNCHANGED, 4'd15, 32'hFFFF_FFFE, 5'd1, 32'd1000}},
        '{ROW_CFG, OP_REGISTER, CFG_DEFAULT_UNIT, 4'd0, 32'hFFFF_FFFF, 32'd0,
          1'b0, '0},
        // cancel of an inactive slot shows the new default unit
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd4, 32'd0, 32'd0,
          1'b1, '{ST_UNCHANGED, 4'd15, 32'hFFFF_FFFE, 5'd1, 32'hFFFF_FFFF}},
        '{ROW_CFG, OP_REGISTER, CFG_MIN_UNIT, 4'd0, 32'h0000_FFFF, 32'd0,
          1'b0, '0},
        // zero interval goes to the front; unit drops to the floor
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd0, 32'd0, 32'd0,
          1'b1, '{ST_CHANGED, 4'd0, 32'd0, 5'd2, 32'd65535}},
        '{ROW_CFG, OP_REGISTER, CFG_MIN_UNIT, 4'd0, 32'd0, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd7, 32'd5000, 32'd1000,
          1'b0, '0},
        '{ROW_CFG, OP_REGISTER, CFG_MIN_UNIT, 4'd0, 32'h0000_FFFF, 32'd0,
          1'b0, '0},
        // floor above the unit: lowering raises it
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd8, 32'd100, 32'hFFFF_FFF0,
          1'b0, '0},
        '{ROW_CFG, OP_REGISTER, CFG_MIN_UNIT, 4'd0, 32'd10, 32'd0,
          1'b0, '0},
        '{ROW_CFG, OP_REGISTER, CFG_DEFAULT_UNIT, 4'd0, 32'd0, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, '0},
        // remove the head, then cancel it again
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd0, 32'hFFFF_FFFF, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd0, 32'd0, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd2, 32'd49, 32'd10,
          1'b0, '0},
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd3, 32'd4, 32'h1234_5678,
          1'b0, '0},
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd15, 32'd0, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_REGISTER, CFG_MIN_UNIT, 4'd9, 32'd1, 32'd0,
          1'b0, '0},
        '{ROW_CMD, OP_CANCEL, CFG_MIN_UNIT, 4'd8, 32'd0, 32'd0,
          1'b0, '0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_operation = OP_REGISTER;
    logic [ID_W-1:0]      i_timer_id = '0;
    logic [TIME_W-1:0]    i_interval_ms = '0;
    logic [TIME_W-1:0]    i_now_ms = '0;
    logic                 o_result_valid;
    logic                 o_status;
    logic [ID_W-1:0]      o_head_timer_id;
    logic [TIME_W-1:0]    o_head_fire_time;
    logic [COUNT_W-1:0]   o_queue_count;
    logic [TIME_W-1:0]    o_scheduling_unit;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_MIN_UNIT;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    // predictor state: slots, fire order and scheduling unit
    logic                 slot_live     [SLOTS];
    logic [TIME_W-1:0]    slot_start_ms [SLOTS];
    logic [TIME_W-1:0]    slot_due_ms   [SLOTS];
    logic [ID_W-1:0]      fire_order    [$];
    logic                 unit_cut;
    logic [TIME_W-1:0]    cut_unit_ms;
    logic [TIME_W-1:0]    floor_unit_ms;
    logic [TIME_W-1:0]    base_unit_ms;

    queue_view_t          pending_views [$];
    queue_view_t          want_view;
    int                   mismatches = 0;
    int                   burst_left = 0;

    wrapping_timer_queue_insert uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_timer_id        (i_timer_id),
        .i_interval_ms     (i_interval_ms),
        .i_now_ms          (i_now_ms),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_head_timer_id   (o_head_timer_id),
        .o_head_fire_time  (o_head_fire_time),
        .o_queue_count     (o_queue_count),
        .o_scheduling_unit (o_scheduling_unit),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // advance the queue by one command and report what the block should show
    function automatic queue_view_t timer_queue_step(input logic op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [TIME_W-1:0] ivl,
                                                     input logic [TIME_W-1:0] now);
        queue_view_t       v;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] slice;
        logic [TIME_W-1:0] cur;
        int                pos;
        int                i;
        v.status = ST_UNCHANGED;
        cur = unit_cut ? cut_unit_ms : base_unit_ms;
        if (op == OP_REGISTER && !slot_live[id]) begin
            due = now + ivl;
            slot_live[id] = 1'b1;
            slot_start_ms[id] = now;
            slot_due_ms[id] = due;
            pos = fire_order.size();
            if (ivl == '0) begin
                pos = 0;
            end else begin
                // first entry whose window, possibly wrapped, holds the new fire time
                for (i = 0; i < fire_order.size(); i++) begin
                    s = slot_start_ms[fire_order[i]];
                    t = slot_due_ms[fire_order[i]];
                    if ((s <= t) ? (due >= s && due < t) : (due >= s || due < t)) begin
                        pos = i;
                        break;
                    end
                end
            end
            fire_order.insert(pos, id);
            slice = ivl / UNIT_DIV;
            if (slice < cur) begin
                cut_unit_ms = (slice > floor_unit_ms) ? slice : floor_unit_ms;
                unit_cut = 1'b1;
            end
            v.status = ST_CHANGED;
        end else if (op == OP_CANCEL && slot_live[id]) begin
            for (i = 0; i < fire_order.size(); i++) begin
                if (fire_order[i] == id) begin
                    fire_order.delete(i);
                    break;
                end
            end
            slot_live[id] = 1'b0;
            v.status = ST_CHANGED;
        end
        if (fire_order.size() > 0) begin
            v.head_id = fire_order[0];
            v.head_fire = slot_due_ms[fire_order[0]];
        end else begin
            v.head_id = '0;
            v.head_fire = '0;
        end
        v.count = COUNT_W'(fire_order.size());
        v.unit = unit_cut ? cut_unit_ms : base_unit_ms;
        return v;
    endfunction

    // write one register once every result is in and the block has settled
    task automatic write_setting(input logic sel, input logic [TIME_W-1:0] data);
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (sel == CFG_MIN_UNIT) begin
            floor_unit_ms = data & 32'h0000_FFFF;
        end else begin
            base_unit_ms = data;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // present a command and hold it until the transfer; start stays high on return
    task automatic send_cmd(input logic op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] ivl, input logic [TIME_W-1:0] now,
                            output queue_view_t view);
        i_operation   <= op;
        i_timer_id    <= id;
        i_interval_ms <= ivl;
        i_now_ms      <= now;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        view = timer_queue_step(op, id, ivl, now);
    endtask

    // end the current burst with a random gap, or carry on back to back
    task automatic sender_gap();
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_views.size() == 0) begin
                $error("result strobe with nothing expected");
                mismatches++;
            end else begin
                want_view = pending_views.pop_front();
                if (o_status !== want_view.status) begin
                    $error("status: expected %0d, got %0d", want_view.status, o_status);
                    mismatches++;
                end
                if (o_head_timer_id !== want_view.head_id) begin
                    $error("head_timer_id: expected %0d, got %0d",
                           want_view.head_id, o_head_timer_id);
                    mismatches++;
                end
                if (o_head_fire_time !== want_view.head_fire) begin
                    $error("head_fire_time: expected %0h, got %0h",
                           want_view.head_fire, o_head_fire_time);
                    mismatches++;
                end
                if (o_queue_count !== want_view.count) begin
                    $error("queue_count: expected %0d, got %0d", want_view.count, o_queue_count);
                    mismatches++;
                end
                if (o_scheduling_unit !== want_view.unit) begin
                    $error("scheduling_unit: expected %0d, got %0d",
                           want_view.unit, o_scheduling_unit);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        queue_view_t       view;
        logic              op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] ivl;
        logic [TIME_W-1:0] tick_ms;
        logic              filling;
        int                changed;
        int                base;
        int                k;
        int                ph;
        int                r;

        // predictor in its reset state
        for (k = 0; k < SLOTS; k++) begin
            slot_live[k] = 1'b0;
            slot_start_ms[k] = '0;
            slot_due_ms[k] = '0;
        end
        unit_cut = 1'b0;
        cut_unit_ms = '0;
        floor_unit_ms = 32'(MIN_UNIT_RST);
        base_unit_ms = DEFAULT_UNIT_RST;
        changed = 0;
        filling = 1'b1;
        tick_ms = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_plan[r].kind == ROW_CFG) begin
                start <= 1'b0;
                write_setting(dir_plan[r].sel, dir_plan[r].data);
            end else begin
                send_cmd(dir_plan[r].op, dir_plan[r].id, dir_plan[r].data, dir_plan[r].now,
                         view);
                pending_views.push_back(dir_plan[r].typed ? dir_plan[r].view : view);
                sender_gap();
            end
        end

        // random phases, each under fresh settings
        for (ph = 0; ph < PHASES; ph++) begin
            start <= 1'b0;
            case ($urandom_range(0, 2))
                0:       write_setting(CFG_MIN_UNIT, '0);
                1:       write_setting(CFG_MIN_UNIT, 32'h0000_FFFF);
                default: write_setting(CFG_MIN_UNIT, $urandom);
            endcase
            write_setting(CFG_DEFAULT_UNIT, ph[0] ? '1 : $urandom);
            tick_ms = ($urandom_range(0, 1) == 0) ? $urandom
                                                  : 32'hFFFF_FFFF - $urandom_range(0, 5000);

            while (changed < (ph + 1) * RANDOM_CHANGES / PHASES) begin
                // swing the occupancy between empty and full
                if (fire_order.size() == SLOTS) begin
                    filling = 1'b0;
                end else if (fire_order.size() == 0) begin
                    filling = 1'b1;
                end else if ($urandom_range(0, 49) == 0) begin
                    filling = !filling;
                end

                if ($urandom_range(0, 9) == 0) begin
                    // noise: any command on any slot
                    op = 1'($urandom_range(0, 1));
                    id = ID_W'($urandom_range(0, SLOTS - 1));
                end else begin
                    if ($urandom_range(0, 4) == 0) begin
                        op = filling ? OP_CANCEL : OP_REGISTER;
                    end else begin
                        op = filling ? OP_REGISTER : OP_CANCEL;
                    end
                    // pick a slot the command will act on, if there is one
                    base = $urandom_range(0, SLOTS - 1);
                    id = ID_W'(base);
                    for (k = 0; k < SLOTS; k++) begin
                        if (slot_live[(base + k) % SLOTS] == (op == OP_CANCEL)) begin
                            id = ID_W'((base + k) % SLOTS);
                            break;
                        end
                    end
                end

                case ($urandom_range(0, 9))
                    0:       ivl = '0;
                    1:       ivl = '1;
                    2, 3:    ivl = $urandom;
                    4:       ivl = 32'h7FFF_FFF0 + $urandom_range(0, 32);
                    default: ivl = $urandom_range(1, 3000);
                endcase
                tick_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);

                send_cmd(op, id, ivl, tick_ms, view);
                pending_views.push_back(view);
                if (view.status == ST_CHANGED) changed++;
                sender_gap();
            end
        end

        // drain and let the block fall quiet
        start <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wtq_pkg.sv
rtl/core/wtq_ram.sv
rtl/core/wtq_unit.sv
rtl/core/wtq_ctrl.sv
rtl/core/wrapping_timer_queue_insert.sv
tb/wrapping_timer_queue_insert_tb.sv
